// ----- src/lnc_pkg.sv -----
// ----------------------------------------------------------------------------
// lnc_pkg
// Shared types, constants and helpers for the LFSR noise channel.
// ----------------------------------------------------------------------------
package lnc_pkg;

  localparam int unsigned LfsrW   = 15;
  localparam int unsigned TimerW  = 22;
  localparam int unsigned LenW    = 7;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned EnvTW   = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 4;

  localparam logic [LfsrW-1:0]  LfsrSeed   = 15'h7FFF;
  localparam int unsigned       NarrowBit  = 6;
  localparam logic [3:0]        ShiftStop  = 4'd14;
  localparam logic [LenW-1:0]   LenFull    = 7'd64;
  localparam logic [LenW-1:0]   LenShort   = 7'd63;
  localparam logic [LevelW-1:0] LevelMax   = 4'hF;
  localparam logic [EnvTW-1:0]  EnvDefault = 4'd8;
  localparam logic [2:0]        StepLast   = 3'd7;

  typedef enum logic [1:0] {
    REQ_TIMER   = 2'd0,
    REQ_LENGTH  = 2'd1,
    REQ_ENVELOPE = 2'd2,
    REQ_TRIGGER = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLOCK_SHIFT     = 3'd0,
    CFG_NARROW_MODE     = 3'd1,
    CFG_DIVISOR_CODE    = 3'd2,
    CFG_LENGTH_COUNTING = 3'd3,
    CFG_ENVELOPE_START  = 3'd4,
    CFG_ENVELOPE_UP     = 3'd5,
    CFG_ENVELOPE_PERIOD = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]        clock_shift;
    logic              narrow_mode;
    logic [2:0]        divisor_code;
    logic              length_counting;
    logic [LevelW-1:0] envelope_start;
    logic              envelope_up;
    logic [2:0]        envelope_period;
  } cfg_t;

  typedef struct packed {
    logic [LevelW-1:0] sample_level;
    logic              channel_on;
    logic              running;
  } res_t;

  // Period timer reload: divisor (8 or code*16) shifted left by clock_shift
  function automatic logic [TimerW-1:0] timer_reload(logic [2:0] code, logic [3:0] shift);
    logic [6:0] base;
    base = (code == 3'd0) ? 7'd8 : {code, 4'b0000};
    return {{(TimerW-7){1'b0}}, base} << shift;
  endfunction

  function automatic logic [EnvTW-1:0] env_reload(logic [2:0] period);
    return (period == 3'd0) ? EnvDefault : {1'b0, period};
  endfunction

endpackage

// ----- src/lfsr_noise_channel_unit.sv -----
// ----------------------------------------------------------------------------
// lfsr_noise_channel_unit
// Noise channel with 15/7-bit LFSR, period timer, length counter and envelope.
// ----------------------------------------------------------------------------
// Each input beat (timer tick, length clock, envelope clock or trigger) updates
// the channel state in one combinational pass and produces one result beat, registered
// and presented the cycle after acceptance. One beat is taken every cycle as
// long as the output register is empty or being drained in the same cycle;
// the output register is the only thing that can stall the input. Config
// registers are written through a plain write port, one register per cycle.
module lfsr_noise_channel_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lnc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lnc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic [2:0]                   frame_step_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [3:0]                   sample_level_o,
  output logic                         channel_on_o,
  output logic                         running_o
);
  import lnc_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic out_valid_q, out_valid_d;
  logic accept;

  lnc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  lnc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .frame_step_i(frame_step_i),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_level_o = res_q.sample_level;
  assign channel_on_o   = res_q.channel_on;
  assign running_o      = res_q.running;

  // A trigger always leaves the channel running
  a_trigger_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_TRIGGER) |=> (out_valid_o && running_o))
    else $error("trigger beat did not report running");

  // A stopped channel is silent and off
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !running_o) |-> (sample_level_o == '0 && !channel_on_o))
    else $error("stopped channel reports sound");

  // Input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

endmodule

// ----- src/lnc_cfg.sv -----
// ----------------------------------------------------------------------------
// lnc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lnc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lnc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lnc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output lnc_pkg::cfg_t                cfg_o
);
  import lnc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CLOCK_SHIFT:     cfg_d.clock_shift     = cfg_wdata_i;
        CFG_NARROW_MODE:     cfg_d.narrow_mode     = cfg_wdata_i[0];
        CFG_DIVISOR_CODE:    cfg_d.divisor_code    = cfg_wdata_i[2:0];
        CFG_LENGTH_COUNTING: cfg_d.length_counting = cfg_wdata_i[0];
        CFG_ENVELOPE_START:  cfg_d.envelope_start  = cfg_wdata_i;
        CFG_ENVELOPE_UP:     cfg_d.envelope_up     = cfg_wdata_i[0];
        CFG_ENVELOPE_PERIOD: cfg_d.envelope_period = cfg_wdata_i[2:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/lnc_core.sv -----
// ----------------------------------------------------------------------------
// lnc_core
// Channel state (LFSR, period timer, length, envelope) and its one-pass update.
// ----------------------------------------------------------------------------
module lnc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [1:0]            req_type_i,
  input  logic [2:0]            frame_step_i,
  input  lnc_pkg::cfg_t         cfg_i,
  output lnc_pkg::res_t         res_o
);
  import lnc_pkg::*;

  logic [LfsrW-1:0]  lfsr_q, lfsr_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [EnvTW-1:0]  env_q, env_d;
  logic              active_q, active_d;

  logic [TimerW-1:0] timer_dec;
  logic [EnvTW-1:0]  env_dec;
  logic [LfsrW-1:0]  lfsr_shift;
  logic              fb;

  always_comb begin
    timer_dec = (timer_q != '0) ? timer_q - 1'b1 : '0;
    env_dec   = (env_q != '0) ? env_q - 1'b1 : '0;
    fb        = lfsr_q[0] ^ lfsr_q[1];
    lfsr_shift = {fb, lfsr_q[LfsrW-1:1]};
    if (cfg_i.narrow_mode) begin
      lfsr_shift[NarrowBit] = fb;
    end
  end

  always_comb begin
    lfsr_d   = lfsr_q;
    timer_d  = timer_q;
    len_d    = len_q;
    level_d  = level_q;
    env_d    = env_q;
    active_d = active_q;
    case (req_e'(req_type_i))
      REQ_TIMER: begin
        timer_d = timer_dec;
        if (timer_dec == '0) begin
          if (cfg_i.clock_shift < ShiftStop) begin
            lfsr_d = lfsr_shift;
          end
          timer_d = timer_reload(cfg_i.divisor_code, cfg_i.clock_shift);
        end
      end
      REQ_LENGTH: begin
        if (cfg_i.length_counting && len_q != '0) begin
          len_d = len_q - 1'b1;
          if (len_q == LenW'(1)) begin
            active_d = 1'b0;
          end
        end
      end
      REQ_ENVELOPE: begin
        env_d = env_dec;
        if (env_dec == '0) begin
          env_d = env_reload(cfg_i.envelope_period);
          if (cfg_i.envelope_period != 3'd0) begin
            if (cfg_i.envelope_up) begin
              if (level_q < LevelMax) level_d = level_q + 1'b1;
            end else if (level_q != '0) begin
              level_d = level_q - 1'b1;
            end
          end
        end
      end
      REQ_TRIGGER: begin
        active_d = 1'b1;
        if (len_q == '0) begin
          len_d = (cfg_i.length_counting && frame_step_i[0]) ? LenShort : LenFull;
        end
        timer_d = timer_reload(cfg_i.divisor_code, cfg_i.clock_shift);
        level_d = cfg_i.envelope_start;
        env_d   = env_reload(cfg_i.envelope_period)
                  + EnvTW'(frame_step_i == StepLast);
        lfsr_d  = LfsrSeed;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q   <= '0;
      timer_q  <= '0;
      len_q    <= '0;
      level_q  <= '0;
      env_q    <= '0;
      active_q <= 1'b0;
    end else if (accept_i) begin
      lfsr_q   <= lfsr_d;
      timer_q  <= timer_d;
      len_q    <= len_d;
      level_q  <= level_d;
      env_q    <= env_d;
      active_q <= active_d;
    end
  end

  // Result reflects the state after this beat
  always_comb begin
    res_o.running      = active_d;
    res_o.channel_on   = active_d && (cfg_i.envelope_start != '0 || cfg_i.envelope_up);
    res_o.sample_level = (active_d && !lfsr_d[0]) ? level_d : '0;
  end

endmodule

// ----- tb/tb_lfsr_noise_channel_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfsr_noise_channel_unit
// Self-checking regression for the LFSR noise channel.
// ----------------------------------------------------------------------------
// A short directed table (reset state, every request, register extremes) runs
// first, then triggered sequences with random bodies under a series of
// register settings. Every accepted beat goes through a cycle-free model of
// the channel. Its result (or a table row's known result) is queued and
// compared field by field with the output beats. Both handshakes idle at
// random, and once the output is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_lfsr_noise_channel_unit;
  import lnc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;  // decodes to nothing
  localparam int unsigned RandBeats = 1150;
  localparam int unsigned PhaseBeats = 190;
  localparam int unsigned MixTick = 0;
  localparam int unsigned MixDrain = 1;
  localparam int unsigned MixEnv = 2;
  localparam int unsigned MixNoise = 3;

  typedef struct packed {
    logic        is_cfg;
    logic        typed;
    logic [2:0]  idx;
    logic [3:0]  wdata;
    req_e        req;
    logic [2:0]  step;
    res_t        known;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          req_type_i = '0;
  logic [2:0]          frame_step_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [3:0]          sample_level_o;
  logic                channel_on_o;
  logic                running_o;

  lfsr_noise_channel_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .frame_step_i   (frame_step_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_level_o (sample_level_o),
    .channel_on_o   (channel_on_o),
    .running_o      (running_o)
  );

  // channel model state
  cfg_t              chan_cfg = '0;
  logic [LfsrW-1:0]  noise_lfsr = '0;
  logic [TimerW-1:0] noise_timer = '0;
  logic [LenW-1:0]   len_count = '0;
  logic [LevelW-1:0] vol_level = '0;
  logic [EnvTW-1:0]  env_count = '0;
  logic              chan_active = 1'b0;

  res_t        pending_samples [$];
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  bit          calm = 1'b0;
  logic        hold_rx = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [TimerW-1:0] tick_reload();
    logic [TimerW-1:0] div;
    div = (chan_cfg.divisor_code == 3'd0) ? TimerW'(8)
                                          : TimerW'({chan_cfg.divisor_code, 4'b0000});
    return div << chan_cfg.clock_shift;
  endfunction

  function automatic logic [EnvTW-1:0] env_restart();
    return (chan_cfg.envelope_period == 3'd0) ? EnvTW'(8) : EnvTW'(chan_cfg.envelope_period);
  endfunction

  // Advances the model by one request and returns the result beat it yields
  function automatic res_t noise_step(req_e r, logic [2:0] s);
    logic fb;
    res_t o;
    case (r)
      REQ_TIMER: begin
        if (noise_timer != 0) noise_timer--;
        if (noise_timer == 0) begin
          if (chan_cfg.clock_shift < ShiftStop) begin
            fb = noise_lfsr[0] ^ noise_lfsr[1];
            noise_lfsr = {fb, noise_lfsr[LfsrW-1:1]};
            if (chan_cfg.narrow_mode) noise_lfsr[6] = fb;
          end
          noise_timer = tick_reload();
        end
      end
      REQ_LENGTH: begin
        if (chan_cfg.length_counting && len_count != 0) begin
          len_count--;
          if (len_count == 0) chan_active = 1'b0;
        end
      end
      REQ_ENVELOPE: begin
        if (env_count != 0) env_count--;
        if (chan_cfg.envelope_period != 0 && env_count == 0) begin
          if (chan_cfg.envelope_up) begin
            if (vol_level != 4'hF) vol_level++;
          end else if (vol_level != 0) begin
            vol_level--;
          end
        end
        if (env_count == 0) env_count = env_restart();
      end
      default: begin
        chan_active = 1'b1;
        if (len_count == 0) len_count = (chan_cfg.length_counting && s[0]) ? 7'd63 : 7'd64;
        noise_timer = tick_reload();
        vol_level = chan_cfg.envelope_start;
        env_count = env_restart() + ((s == 3'd7) ? 4'd1 : 4'd0);
        noise_lfsr = 15'h7FFF;
      end
    endcase
    o.sample_level = (chan_active && !noise_lfsr[0]) ? vol_level : 4'd0;
    o.channel_on = chan_active && (chan_cfg.envelope_start != 0 || chan_cfg.envelope_up);
    o.running = chan_active;
    return o;
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_e pick_req(int unsigned mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MixTick:  return r < 70 ? REQ_TIMER : r < 80 ? REQ_LENGTH : r < 95 ? REQ_ENVELOPE : REQ_TRIGGER;
      MixDrain: return r < 20 ? REQ_TIMER : r < 85 ? REQ_LENGTH : r < 98 ? REQ_ENVELOPE : REQ_TRIGGER;
      MixEnv:   return r < 25 ? REQ_TIMER : r < 35 ? REQ_LENGTH : r < 96 ? REQ_ENVELOPE : REQ_TRIGGER;
      default:  return req_e'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic plan_row_t cfg_row(cfg_idx_e idx, logic [3:0] v);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.wdata = v;
    return row;
  endfunction

  function automatic plan_row_t beat_row(req_e r, logic [2:0] s);
    plan_row_t row;
    row = '0;
    row.req = r;
    row.step = s;
    return row;
  endfunction

  function automatic plan_row_t known_row(req_e r, logic [2:0] s, res_t e);
    plan_row_t row;
    row = beat_row(r, s);
    row.typed = 1'b1;
    row.known = e;
    return row;
  endfunction

  task automatic send_beat(req_e r, logic [2:0] s, logic typed, res_t known);
    int unsigned gap;
    res_t model;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= r;
    frame_step_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    model = noise_step(r, s);
    pending_samples.push_back(typed ? known : model);
    beats_in++;
  endtask

  // drain everything before touching the registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [3:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    case (idx)
      CFG_CLOCK_SHIFT:     chan_cfg.clock_shift = v;
      CFG_NARROW_MODE:     chan_cfg.narrow_mode = v[0];
      CFG_DIVISOR_CODE:    chan_cfg.divisor_code = v[2:0];
      CFG_LENGTH_COUNTING: chan_cfg.length_counting = v[0];
      CFG_ENVELOPE_START:  chan_cfg.envelope_start = v;
      CFG_ENVELOPE_UP:     chan_cfg.envelope_up = v[0];
      CFG_ENVELOPE_PERIOD: chan_cfg.envelope_period = v[2:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_result();
    res_t want;
    if (pending_samples.size() == 0) begin
      note_mismatch("result beat with nothing expected");
    end else begin
      want = pending_samples.pop_front();
      if (sample_level_o !== want.sample_level)
        note_mismatch($sformatf("sample_level %0d, expected %0d", sample_level_o,
                                want.sample_level));
      if (channel_on_o !== want.channel_on)
        note_mismatch($sformatf("channel_on %0b, expected %0b", channel_on_o, want.channel_on));
      if (running_o !== want.running)
        note_mismatch($sformatf("running %0b, expected %0b", running_o, want.running));
    end
  endtask

  // result side: random stalls plus the long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_result();
      if (stall_left != 0) stall_left--;
      else stall_left = pick_gap();
      out_ready_i <= !hold_rx && stall_left == 0;
    end
  end

  // hold the output long enough that the block backs up into its input
  initial begin
    wait (beats_in >= 600);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("lfsr_noise_channel_unit regression: fail");
    $finish;
  end

  initial begin
    plan_row_t   plan [$];
    cfg_t        next;
    int unsigned phase;
    int unsigned start_beats;
    int unsigned body;
    int unsigned mix;
    int unsigned rand_start;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = {
      // reset state: nothing runs until the first trigger
      known_row(REQ_TIMER, 3'd0, res_t'{4'd0, 1'b0, 1'b0}),
      known_row(REQ_LENGTH, 3'd5, res_t'{4'd0, 1'b0, 1'b0}),
      known_row(REQ_ENVELOPE, 3'd2, res_t'{4'd0, 1'b0, 1'b0}),
      known_row(REQ_TRIGGER, 3'd0, res_t'{4'd0, 1'b0, 1'b1}),
      cfg_row(CFG_LENGTH_COUNTING, 4'd1),
      cfg_row(CFG_ENVELOPE_START, 4'd15),
      cfg_row(CFG_ENVELOPE_PERIOD, 4'd1),
      cfg_row(CFG_NARROW_MODE, 4'd1),
      // step 7 trigger stretches the first envelope period
      known_row(REQ_TRIGGER, 3'd7, res_t'{4'd0, 1'b1, 1'b1}),
      beat_row(REQ_TIMER, 3'd1), beat_row(REQ_TIMER, 3'd6), beat_row(REQ_TIMER, 3'd4),
      beat_row(REQ_ENVELOPE, 3'd7), beat_row(REQ_ENVELOPE, 3'd0), beat_row(REQ_ENVELOPE, 3'd3),
      beat_row(REQ_LENGTH, 3'd2), beat_row(REQ_LENGTH, 3'd5),
      cfg_row(CFG_CLOCK_SHIFT, 4'd15),
      cfg_row(CFG_DIVISOR_CODE, 4'd7),
      cfg_row(CFG_ENVELOPE_UP, 4'd1),
      cfg_row(CFG_ENVELOPE_START, 4'd0),
      cfg_row(CFG_ENVELOPE_PERIOD, 4'd7),
      known_row(REQ_TRIGGER, 3'd1, res_t'{4'd0, 1'b1, 1'b1}),
      beat_row(REQ_TIMER, 3'd2), beat_row(REQ_TIMER, 3'd5),
      beat_row(REQ_ENVELOPE, 3'd4), beat_row(REQ_LENGTH, 3'd1),
      cfg_row(CFG_CLOCK_SHIFT, 4'd14),
      cfg_row(CFG_ENVELOPE_UP, 4'd0),
      // silent start volume, falling envelope: running but not on
      known_row(REQ_TRIGGER, 3'd3, res_t'{4'd0, 1'b0, 1'b1}),
      beat_row(REQ_TIMER, 3'd6)
    };

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) wait_idle();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_beat(plan[i].req, plan[i].step, plan[i].typed, plan[i].known);
      end
    end

    rand_start = beats_in;
    phase = 0;
    while (beats_in - rand_start < RandBeats) begin
      wait_idle();
      if (phase == 0) begin
        next = '0;
      end else if (phase == 1) begin
        next = '1;
      end else begin
        next.clock_shift = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3))
                                                         : 4'($urandom_range(0, 15));
        next.narrow_mode = 1'($urandom);
        next.divisor_code = ($urandom_range(0, 99) < 60) ? 3'($urandom_range(0, 1))
                                                          : 3'($urandom_range(0, 7));
        next.length_counting = $urandom_range(0, 3) != 0;
        next.envelope_start = 4'($urandom);
        next.envelope_up = 1'($urandom);
        next.envelope_period = 3'($urandom);
      end
      // upper data bits of narrow registers carry junk that must be ignored
      write_reg(CFG_CLOCK_SHIFT, next.clock_shift);
      write_reg(CFG_NARROW_MODE, {3'($urandom), next.narrow_mode});
      write_reg(CFG_DIVISOR_CODE, {1'($urandom), next.divisor_code});
      write_reg(CFG_LENGTH_COUNTING, {3'($urandom), next.length_counting});
      write_reg(CFG_ENVELOPE_START, next.envelope_start);
      write_reg(CFG_ENVELOPE_UP, {3'($urandom), next.envelope_up});
      write_reg(CFG_ENVELOPE_PERIOD, {1'($urandom), next.envelope_period});
      write_reg(CfgIdxSpare, 4'($urandom));
      calm = ($urandom_range(0, 3) == 0);

      start_beats = beats_in;
      while (beats_in - start_beats < PhaseBeats && beats_in - rand_start < RandBeats) begin
        // one triggered note with a random body
        mix = ($urandom_range(0, 9) == 0) ? MixNoise : $urandom_range(MixTick, MixEnv);
        body = $urandom_range(20, 160);
        send_beat(REQ_TRIGGER, 3'($urandom), 1'b0, '0);
        repeat (body) begin
          if (beats_in - rand_start < RandBeats)
            send_beat(pick_req(mix), 3'($urandom), 1'b0, '0);
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    for (int n = 0; n < 5000 && pending_samples.size() != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_samples.size() != 0)
      note_mismatch($sformatf("%0d expected beats never arrived", pending_samples.size()));

    if (mismatches == 0) begin
      $display("lfsr_noise_channel_unit regression: pass");
    end else begin
      $display("lfsr_noise_channel_unit regression: fail");
    end
    $finish;
  end

endmodule
